>>> sv/mu_law_compressor_unit_macros.svh
// assertion macros for the mu-law compressor checker
`ifndef MU_LAW_COMPRESSOR_UNIT_MACROS_SVH
`define MU_LAW_COMPRESSOR_UNIT_MACROS_SVH

// implication checked in the same cycle
`define MLC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mlc checker: same-cycle rule violated");

// implication checked in the next cycle
`define MLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mlc checker: next-cycle rule violated");

`endif

>>> sv/mlc_pkg.sv
// shared types and constants of the mu-law compressor
package mlc_pkg;

  localparam int LOG_FRAC  = 30;
  localparam int MU_W      = 16;
  localparam int MANT_W    = 32;
  localparam int LSI_W     = 32;
  localparam int EXP_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MU    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT = 1'b1;

  // request travelling down the log2 chain
  typedef struct packed {
    logic                valid;
    logic                neg;
    logic                err;
    logic                last;
    logic [EXP_W-1:0]    e;
    logic [MANT_W-1:0]   m;
    logic [LOG_FRAC-1:0] frac;
  } cell_t;

endpackage

>>> sv/mlc_cell.sv
// one squaring cell of the log2 chain, yields one fraction bit
module mlc_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  mlc_pkg::cell_t d_i,
  output mlc_pkg::cell_t q_o
);
  import mlc_pkg::*;

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     t;
  logic                bit_n;
  cell_t               cell_d;
  cell_t               cell_q;

  // square the mantissa, renormalise, shift in the fraction bit
  always_comb begin
    sq            = (2*MANT_W)'(d_i.m) * (2*MANT_W)'(d_i.m);
    t             = sq[2*MANT_W-1:MANT_W-1];
    bit_n         = t[MANT_W];
    cell_d        = d_i;
    cell_d.m      = bit_n ? t[MANT_W:1] : t[MANT_W-1:0];
    cell_d.frac   = {d_i.frac[LOG_FRAC-2:0], bit_n};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

>>> sv/mlc_scale.sv
// sequencer that works out 1/log2(1+mu) in unsigned Q1.31
module mlc_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mlc_pkg::MU_W-1:0]  meff_i,
  output logic                      busy_o,
  output logic [mlc_pkg::LSI_W-1:0] lsi_o
);
  import mlc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_LOG  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  localparam int VW  = MU_W + 1;
  localparam int KW  = $clog2(VW);
  localparam int DW  = EXP_W + LOG_FRAC;
  localparam int NUMW = 62;
  localparam int CW  = $clog2(NUMW);

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [MANT_W-1:0]   m_q, m_d;
  logic [EXP_W-1:0]    e_q, e_d;
  logic [LOG_FRAC-1:0] frac_q, frac_d;
  logic [NUMW-1:0]     num_q, num_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [LSI_W-1:0]    quo_q, quo_d;

  logic [VW-1:0]       v;
  logic [KW-1:0]       k;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     t;
  logic [DW-1:0]       den;
  logic [DW:0]         rem_sh;

  // leading one of 1+mu and the squaring step
  always_comb begin
    v = VW'(meff_i) + VW'(1);
    k = '0;
    for (int i = 0; i < VW; i++) begin
      if (v[i]) k = KW'(i);
    end
    sq     = (2*MANT_W)'(m_q) * (2*MANT_W)'(m_q);
    t      = sq[2*MANT_W-1:MANT_W-1];
    den    = {e_q, frac_q};
    rem_sh = {rem_q, num_q[NUMW-1]};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    m_d     = m_q;
    e_d     = e_q;
    frac_d  = frac_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    case (state_q)
      ST_IDLE: begin
      end
      ST_PREP: begin
        m_d     = MANT_W'(v) << (5'(MANT_W - 1) - 5'(k));
        e_d     = EXP_W'(k);
        cnt_d   = CW'(LOG_FRAC - 1);
        state_d = ST_LOG;
      end
      ST_LOG: begin
        m_d    = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        frac_d = {frac_q[LOG_FRAC-2:0], t[MANT_W]};
        cnt_d  = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          state_d = ST_DIV;
          cnt_d   = CW'(NUMW - 1);
        end
      end
      ST_DIV: begin
        if (cnt_q == CW'(NUMW - 1) && num_q == '0 && rem_q == '0) begin
          // first step loads the numerator 2^61 + den/2
          num_d = (NUMW'(1) << 61) + NUMW'(den >> 1);
          rem_d = '0;
          quo_d = '0;
          cnt_d = CW'(NUMW - 1);
          state_d = ST_DIV;
        end
        if (!(cnt_q == CW'(NUMW - 1) && num_q == '0 && rem_q == '0)) begin
          num_d = {num_q[NUMW-2:0], 1'b0};
          if (rem_sh >= (DW+1)'(den)) begin
            rem_d = DW'(rem_sh - (DW+1)'(den));
            quo_d = {quo_q[LSI_W-2:0], 1'b1};
          end else begin
            rem_d = rem_sh[DW-1:0];
            quo_d = {quo_q[LSI_W-2:0], 1'b0};
          end
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == '0) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (start_i) state_d = ST_PREP;
    if (state_q == ST_LOG && cnt_q == '0) begin
      num_d = '0;
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_PREP;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    e_q    <= e_d;
    frac_q <= frac_d;
    num_q  <= num_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign lsi_o  = quo_q;

endmodule

>>> sv/mu_law_compressor_unit.sv
// mu-law compressor top level: front end, log2 cell chain, scale and bin stages
// throughput: one request per cycle, held back by a stalled output or a busy scale sequencer
// the pipeline moves as one; a stalled output register stalls every stage
// after reset and after each mu write the scale sequencer runs, and while it is
// busy no request is accepted; reset clears all valid flags
module mu_law_compressor_unit #(
  parameter int FRAC_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mlc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mlc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [FRAC_BITS+1:0]         sample_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [FRAC_BITS+1:0]         value_o,
  output logic                                range_error_o,
  output logic                                last_out_o
);
  import mlc_pkg::*;

  localparam int IOW  = FRAC_BITS + 2;
  localparam int XW   = FRAC_BITS + 18;
  localparam int KW   = $clog2(XW);
  localparam int NW   = (XW > MANT_W) ? XW : MANT_W;
  localparam int SHW  = $clog2(NW);
  localparam int LW   = EXP_W + LOG_FRAC;
  localparam int LOW  = 18;
  localparam int HIW  = LW - LOW;
  localparam int SW   = 68;
  localparam int YW   = FRAC_BITS + 1;
  localparam int QW   = FRAC_BITS + 18;
  localparam int BW   = FRAC_BITS + 19;
  localparam logic [IOW-1:0] ONE_IO = IOW'(1) << FRAC_BITS;
  localparam logic [SW-1:0]  RND    = SW'(1) << (60 - FRAC_BITS);
  localparam logic [BW-1:0]  QRND   = (BW'(1) << (FRAC_BITS + 1)) - BW'(1);

  // configuration
  logic [MU_W-1:0]  mu_q;
  logic             quant_q;
  logic [MU_W-1:0]  meff;
  logic             busy;
  logic [LSI_W-1:0] lsi;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q    <= MU_W'(255);
      quant_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_MU)    mu_q    <= cfg_data_i[MU_W-1:0];
      if (cfg_index_i == REG_QUANT) quant_q <= cfg_data_i[0];
    end
  end

  assign meff = (mu_q == '0) ? MU_W'(1) : mu_q;

  mlc_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i && cfg_index_i == REG_MU),
    .meff_i  (meff),
    .busy_o  (busy),
    .lsi_o   (lsi)
  );

  // global advance
  logic adv;
  logic accept;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = busy || !adv;
  assign accept     = in_valid_i && !in_stall_o;

  // front end: magnitude, range check, 2^F + mu*|v|
  logic [IOW-1:0] raw, mag;
  logic           neg;
  logic [XW-1:0]  x_d;
  logic           a_v_q, a_neg_q, a_err_q, a_last_q;
  logic [XW-1:0]  a_x_q;

  always_comb begin
    raw = sample_i;
    neg = raw[IOW-1];
    mag = neg ? (IOW'(0) - raw) : raw;
    x_d = XW'(ONE_IO) + XW'(meff) * XW'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_neg_q  <= neg;
      a_err_q  <= (mag > ONE_IO);
      a_last_q <= last_sample_i;
      a_x_q    <= x_d;
    end
  end

  // leading one search
  logic [KW-1:0] k_d;
  logic          b_v_q, b_neg_q, b_err_q, b_last_q;
  logic [XW-1:0] b_x_q;
  logic [KW-1:0] b_k_q;

  always_comb begin
    k_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (a_x_q[i]) k_d = KW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (adv) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b_neg_q  <= a_neg_q;
      b_err_q  <= a_err_q;
      b_last_q <= a_last_q;
      b_x_q    <= a_x_q;
      b_k_q    <= k_d;
    end
  end

  // normalise the mantissa to 32 bits and enter the chain
  logic [NW-1:0] wide;
  cell_t         head_d;
  cell_t         chain [LOG_FRAC+1];

  always_comb begin
    wide          = NW'(b_x_q) << (SHW'(NW - 1) - SHW'(b_k_q));
    head_d        = '0;
    head_d.valid  = b_v_q;
    head_d.neg    = b_neg_q;
    head_d.err    = b_err_q;
    head_d.last   = b_last_q;
    head_d.e      = EXP_W'(b_k_q - KW'(FRAC_BITS));
    head_d.m      = wide[NW-1 -: MANT_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain[0] <= '0;
    end else if (adv) begin
      chain[0] <= head_d;
    end
  end

  // chain of squaring cells, one fraction bit each
  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_cell
    mlc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .d_i    (chain[g]),
      .q_o    (chain[g+1])
    );
  end

  // scale multiply, split into two partial products
  cell_t                tail;
  logic [LW-1:0]        lnum;
  logic                 p_v_q, p_neg_q, p_err_q, p_last_q;
  logic [LOW+LSI_W-1:0] p_lo_q;
  logic [HIW+LSI_W-1:0] p_hi_q;

  assign tail = chain[LOG_FRAC];
  assign lnum = {tail.e, tail.frac};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (adv) begin
      p_v_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_neg_q  <= tail.neg;
      p_err_q  <= tail.err;
      p_last_q <= tail.last;
      p_lo_q   <= (LOW+LSI_W)'(lnum[LOW-1:0]) * (LOW+LSI_W)'(lsi);
      p_hi_q   <= (HIW+LSI_W)'(lnum[LW-1:LOW]) * (HIW+LSI_W)'(lsi);
    end
  end

  // sum, round and cap at one
  logic [SW-1:0] sum, yfull;
  logic [YW-1:0] y_d;
  logic          y_v_q, y_neg_q, y_err_q, y_last_q;
  logic [YW-1:0] y_q;

  always_comb begin
    sum   = (SW'(p_hi_q) << LOW) + SW'(p_lo_q) + RND;
    yfull = sum >> (61 - FRAC_BITS);
    y_d   = (yfull > SW'(ONE_IO)) ? YW'(ONE_IO) : yfull[YW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_v_q <= 1'b0;
    end else if (adv) begin
      y_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_neg_q  <= p_neg_q;
      y_err_q  <= p_err_q;
      y_last_q <= p_last_q;
      y_q      <= y_d;
    end
  end

  // bin numerator (y+1)*mu
  logic [IOW-1:0] shifted;
  logic           n_v_q, n_neg_q, n_err_q, n_last_q;
  logic [YW-1:0]  n_y_q;
  logic [QW-1:0]  n_num_q;

  assign shifted = y_neg_q ? (ONE_IO - IOW'(y_q)) : (ONE_IO + IOW'(y_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_v_q <= 1'b0;
    end else if (adv) begin
      n_v_q <= y_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_neg_q  <= y_neg_q;
      n_err_q  <= y_err_q;
      n_last_q <= y_last_q;
      n_y_q    <= y_q;
      n_num_q  <= QW'(shifted) * QW'(meff);
    end
  end

  // result select and output register
  logic [BW-1:0]  binsum;
  logic [IOW-1:0] bin_idx, off, res;
  logic           o_v_q, o_err_q, o_last_q;
  logic [IOW-1:0] o_val_q;

  always_comb begin
    binsum  = BW'(n_num_q) + QRND;
    bin_idx = IOW'(binsum >> (FRAC_BITS + 1));
    off     = IOW'((17'(meff) + 17'd1) >> 1);
    if (n_err_q) begin
      res = '0;
    end else if (quant_q) begin
      res = bin_idx - off;
    end else begin
      res = n_neg_q ? (IOW'(0) - IOW'(n_y_q)) : IOW'(n_y_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (adv) begin
      o_v_q <= n_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_err_q  <= n_err_q;
      o_last_q <= n_last_q;
      o_val_q  <= res;
    end
  end

  assign out_valid_o   = o_v_q;
  assign value_o       = $signed(o_val_q);
  assign range_error_o = o_err_q;
  assign last_out_o    = o_last_q;

endmodule

>>> sv/mlc_checker.sv
// port-level checker for the mu-law compressor, bound to the top level
`include "mu_law_compressor_unit_macros.svh"

module mlc_checker #(
  parameter int FRAC_BITS = 15
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [FRAC_BITS+1:0]   value_o,
  input logic                          range_error_o
);

  // an out-of-range request yields a zero value
  `MLC_ASSERT_NOW(a_err_zero, out_valid_o && range_error_o, value_o == '0)

  // a held result backs up the input side at once
  `MLC_ASSERT_NOW(a_back_pressure, out_valid_o && out_stall_i, in_stall_o)

  // a stalled result stays put
  `MLC_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(value_o))

endmodule

bind mu_law_compressor_unit mlc_checker #(.FRAC_BITS(FRAC_BITS)) u_mlc_checker (.*);
